/* design/assert_macros.svh */
// Assertion helpers for the RTL files; included by the top-level file.
// The clock and reset in scope must be named clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`else

`define ASSERT_IMP(lbl, ante, cons)
`define ASSERT_NXT(lbl, ante, cons)

`endif

`endif

/* design/fspl_pkg.sv */
package fspl_pkg;

  // Port and gain widths
  localparam int SPEED_W = 16;
  localparam int GAIN_W  = 16;
  localparam int DRIVE_W = 16;

  // Q.8 filter state
  localparam int STATE_W = 24;
  localparam int DLT_W   = STATE_W + 1;

  // Low-pass mix 4*F + 256*s and its magnitude
  localparam int MIX_W = 27;
  localparam int MAG_W = MIX_W - 1;

  // Divide by 5: multiply by ceil(2^29/5), exact for magnitudes below 2^26
  localparam int                 RECIP5_W  = 27;
  localparam int                 RECIP5_SH = 29;
  localparam logic [RECIP5_W-1:0] RECIP5   = 27'd107374183;
  localparam int                 QPROD5_W  = MAG_W + RECIP5_W;

  // Integral clamp (10000.0 in Q.8)
  localparam logic signed [DLT_W-1:0] INT_HI = 25'sd2560000;
  localparam logic signed [DLT_W-1:0] INT_LO = -25'sd2560000;

  // Largest filtered value reachable from 16-bit samples
  localparam logic signed [STATE_W-1:0] FILT_MAX = 24'sd8388352;

  // Gain stage widths
  localparam int LIN_W  = 34;
  localparam int PROD_W = 50;
  localparam int NSUM_W = PROD_W + 1;

  // Drive scaling: N / (200 * 65536) = (N >> 19) / 25
  localparam int                  DRV_SH     = 19;
  localparam int                  NSHIFT_W   = NSUM_W - DRV_SH;
  localparam int                  QMAG_W     = 20;
  localparam logic [QMAG_W-1:0]   QMAG_LIM   = 20'd819225;
  localparam int                  RECIP25_W  = 21;
  localparam int                  RECIP25_SH = 25;
  localparam logic [RECIP25_W-1:0] RECIP25   = 21'd1342178;
  localparam int                  QPROD25_W  = QMAG_W + RECIP25_W;
  localparam int                  QDIV_W     = 16;

  // Configuration register indexes
  localparam logic REG_KP = 1'b0;
  localparam logic REG_KD = 1'b1;
  localparam int   ADDR_W = 3;
  localparam int   DATA_W = 32;

  // Item from the filter stage to the gain stage
  typedef struct packed {
    logic signed [STATE_W-1:0] filt;
    logic signed [STATE_W-1:0] integ;
    logic signed [DLT_W-1:0]   dlt;
  } filt_item_t;

  // Item from the gain stage to the scale stage
  typedef struct packed {
    logic signed [PROD_W-1:0] p_prop;
    logic signed [PROD_W-1:0] p_der;
  } gain_item_t;

endpackage

/* design/fspl_filter.sv */
module fspl_filter import fspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SPEED_W-1:0] in_speed,
  output logic                      o_valid,
  input  logic                      o_ready,
  output filt_item_t                o_item
);

  logic                      v1_r, v2_r, v3_r;
  logic                      en1, en2, en3;
  logic signed [SPEED_W-1:0] s1_r;
  logic signed [STATE_W-1:0] filt_r, integ_r;
  logic signed [STATE_W-1:0] f2_r, p2_r;
  logic signed [MIX_W-1:0]   mix;
  logic        [MIX_W-1:0]   mix_neg;
  logic        [MAG_W-1:0]   mix_mag;
  logic        [QPROD5_W-1:0] quo_prod;
  logic        [STATE_W-1:0] quo;
  logic signed [STATE_W-1:0] filt_nxt;
  logic signed [DLT_W-1:0]   isum;
  logic signed [STATE_W-1:0] integ_nxt;
  filt_item_t                item_r;

  // Stage advance: a stage moves when it is empty or the next one moves
  assign en3      = !v3_r || o_ready;
  assign en2      = !v2_r || en3;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;
  assign o_valid  = v3_r;
  assign o_item   = item_r;

  // Low-pass: F' = trunc0((4F + 256s) / 5) via reciprocal multiply on magnitude
  assign mix      = {filt_r[STATE_W-1], filt_r, 2'b00}
                  + {{3{s1_r[SPEED_W-1]}}, s1_r, 8'b0};
  assign mix_neg  = -mix;
  assign mix_mag  = mix[MIX_W-1] ? mix_neg[MAG_W-1:0] : mix[MAG_W-1:0];
  assign quo_prod = {{RECIP5_W{1'b0}}, mix_mag} * {{MAG_W{1'b0}}, RECIP5};
  assign quo      = quo_prod[RECIP5_SH +: STATE_W];
  assign filt_nxt = mix[MIX_W-1] ? $signed(~quo + 24'd1) : $signed(quo);

  // Integral accumulate with clamp
  assign isum = {integ_r[STATE_W-1], integ_r} + {f2_r[STATE_W-1], f2_r};
  always_comb begin
    if (isum >= INT_HI) begin
      integ_nxt = INT_HI[STATE_W-1:0];
    end else if (isum <= INT_LO) begin
      integ_nxt = INT_LO[STATE_W-1:0];
    end else begin
      integ_nxt = isum[STATE_W-1:0];
    end
  end

  // Valid bits and loop state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r    <= 1'b0;
      v2_r    <= 1'b0;
      v3_r    <= 1'b0;
      filt_r  <= '0;
      integ_r <= '0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en2 && v1_r) filt_r <= filt_nxt;
      if (en3 && v2_r) integ_r <= integ_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (en1 && in_valid) begin
      s1_r <= in_speed;
    end
    if (en2 && v1_r) begin
      f2_r <= filt_nxt;
      p2_r <= filt_r;
    end
    if (en3 && v2_r) begin
      item_r.filt  <= f2_r;
      item_r.integ <= integ_nxt;
      item_r.dlt   <= {f2_r[STATE_W-1], f2_r} - {p2_r[STATE_W-1], p2_r};
    end
  end

endmodule

/* design/fspl_gain.sv */
module fspl_gain import fspl_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [GAIN_W-1:0] kp,
  input  logic signed [GAIN_W-1:0] kd,
  input  logic                     i_valid,
  output logic                     i_ready,
  input  filt_item_t               i_item,
  output logic                     o_valid,
  input  logic                     o_ready,
  output gain_item_t               o_item
);

  logic                    v4_r, v5_r;
  logic                    en4, en5;
  logic signed [LIN_W-1:0] f_x, i_x, d_x;
  logic signed [LIN_W-1:0] lin_a_r, lin_b_r;
  gain_item_t              item_r;

  assign en5     = !v5_r || o_ready;
  assign en4     = !v4_r || en5;
  assign i_ready = en4;
  assign o_valid = v5_r;
  assign o_item  = item_r;

  // Sign-extend the Q.8 terms
  assign f_x = LIN_W'(i_item.filt);
  assign i_x = LIN_W'(i_item.integ);
  assign d_x = LIN_W'(i_item.dlt);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else begin
      if (en4) v4_r <= i_valid;
      if (en5) v5_r <= v4_r;
    end
  end

  // 200*F + I and 200*dF, then one gain multiply each
  always_ff @(posedge clk) begin
    if (en4 && i_valid) begin
      lin_a_r <= f_x * 34'sd200 + i_x;
      lin_b_r <= d_x * 34'sd200;
    end
    if (en5 && v4_r) begin
      item_r.p_prop <= PROD_W'(kp) * PROD_W'(lin_a_r);
      item_r.p_der  <= PROD_W'(kd) * PROD_W'(lin_b_r);
    end
  end

endmodule

/* design/fspl_scale.sv */
module fspl_scale import fspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      i_valid,
  output logic                      i_ready,
  input  gain_item_t                i_item,
  output logic                      o_valid,
  input  logic                      o_ready,
  output logic signed [DRIVE_W-1:0] o_drive
);

  logic                       v6_r, v7_r, v8_r;
  logic                       en6, en7, en8;
  logic signed [NSUM_W-1:0]   nsum_r;
  logic        [NSUM_W-1:0]   nabs;
  logic        [NSHIFT_W-1:0] nshift;
  logic        [QMAG_W-1:0]   qmag;
  logic        [QMAG_W-1:0]   qmag_r;
  logic                       neg_r;
  logic        [QPROD25_W-1:0] qprod;
  logic        [QDIV_W-1:0]   qdiv;
  logic signed [DRIVE_W-1:0]  drive_nxt;
  logic signed [DRIVE_W-1:0]  drive_r;

  assign en8     = !v8_r || o_ready;
  assign en7     = !v7_r || en8;
  assign en6     = !v6_r || en7;
  assign i_ready = en6;
  assign o_valid = v8_r;
  assign o_drive = drive_r;

  // Magnitude of N >> 19, clamped so the divide by 25 still saturates
  assign nabs   = nsum_r[NSUM_W-1] ? -nsum_r : nsum_r;
  assign nshift = nabs[NSUM_W-1:DRV_SH];
  assign qmag   = (nshift > NSHIFT_W'(QMAG_LIM)) ? QMAG_LIM : nshift[QMAG_W-1:0];

  // Divide by 25 via reciprocal, then restore sign and saturate
  assign qprod = {{RECIP25_W{1'b0}}, qmag_r} * {{QMAG_W{1'b0}}, RECIP25};
  assign qdiv  = qprod[RECIP25_SH +: QDIV_W];
  always_comb begin
    if (neg_r) begin
      if (qdiv > 16'd32768) begin
        drive_nxt = 16'sh8000;
      end else begin
        drive_nxt = $signed(~qdiv + 16'd1);
      end
    end else begin
      if (qdiv > 16'd32767) begin
        drive_nxt = 16'sh7fff;
      end else begin
        drive_nxt = $signed(qdiv);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else begin
      if (en6) v6_r <= i_valid;
      if (en7) v7_r <= v6_r;
      if (en8) v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en6 && i_valid) begin
      nsum_r <= NSUM_W'(i_item.p_prop) + NSUM_W'(i_item.p_der);
    end
    if (en7 && v6_r) begin
      qmag_r <= qmag;
      neg_r  <= nsum_r[NSUM_W-1];
    end
    if (en8 && v7_r) begin
      drive_r <= drive_nxt;
    end
  end

endmodule

/* design/filtered_speed_pid_loop.sv */
// Channel  | Direction | Handshake            | Payload
// in_      | input     | in_valid / in_ready  | in_encoder_speed (s16)
// out_     | output    | out_valid / out_ready| out_drive (s16)
// config   | input     | APB psel / penable   | paddr, pwdata, prdata (kp at 0, kd at 4)
//
// One item per cycle sustained while out_ready is high; eight register stages to out_valid.
// The low-pass recurrence closes through filt_r (reciprocal multiply by 1/5), the integral
// in the stage after; gain multiplies and drive scaling follow as a feed-forward pipe.
// rst_n is synchronous: it clears stage valid bits, filter state, integral and gains.
// A full stage holds while the next one holds, so input is taken while bubbles remain.
`include "assert_macros.svh"

module filtered_speed_pid_loop import fspl_pkg::*; (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [SPEED_W-1:0] in_encoder_speed,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [DRIVE_W-1:0] out_drive,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  logic signed [GAIN_W-1:0] kp_r, kd_r;
  logic                     reg_idx;
  logic                     cfg_wr;
  logic                     filt_valid, filt_ready;
  filt_item_t               filt_item;
  logic                     gain_valid, gain_ready;
  gain_item_t               gain_item;

  // Register file
  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kp_r <= '0;
      kd_r <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_KP:  kp_r <= pwdata[GAIN_W-1:0];
        REG_KD:  kd_r <= pwdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_KP:  prdata = DATA_W'(kp_r);
      REG_KD:  prdata = DATA_W'(kd_r);
      default: prdata = '0;
    endcase
  end

  // Low-pass filter and integral
  fspl_filter u_filter (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_speed (in_encoder_speed),
    .o_valid  (filt_valid),
    .o_ready  (filt_ready),
    .o_item   (filt_item)
  );

  // Gain products
  fspl_gain u_gain (
    .clk     (clk),
    .rst_n   (rst_n),
    .kp      (kp_r),
    .kd      (kd_r),
    .i_valid (filt_valid),
    .i_ready (filt_ready),
    .i_item  (filt_item),
    .o_valid (gain_valid),
    .o_ready (gain_ready),
    .o_item  (gain_item)
  );

  // Drive scaling and saturation
  fspl_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .i_valid (gain_valid),
    .i_ready (gain_ready),
    .i_item  (gain_item),
    .o_valid (out_valid),
    .o_ready (out_ready),
    .o_drive (out_drive)
  );

  // Checks
  `ASSERT_IMP(a_ready_when_drained, !out_valid, in_ready)
  `ASSERT_IMP(a_integ_clamped, filt_valid, (filt_item.integ <= INT_HI) && (filt_item.integ >= INT_LO))
  `ASSERT_IMP(a_filt_bounded, filt_valid, filt_item.filt <= FILT_MAX)
  `ASSERT_NXT(a_kp_write, cfg_wr && (reg_idx == REG_KP), kp_r == $past(pwdata[GAIN_W-1:0]))

endmodule
